[hw/rtl/lru_block_buffer_cache_core_defines.svh]
// Assertion macros for the block buffer cache core.
// Depends on nothing; included by the top level, which supplies i_clk and i_rst_n.
`ifndef LRU_BLOCK_BUFFER_CACHE_CORE_DEFINES_SVH
`define LRU_BLOCK_BUFFER_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbc check failed");

// Next-cycle implication, checked outside reset.
`define LBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbc check failed");

`endif

[hw/rtl/lbc_pkg.sv]
// Shared types and constants of the block buffer cache core.
// Used by lbc_cell and lru_block_buffer_cache_core; depends on nothing.
package lbc_pkg;

    localparam int NUM_SLOTS   = 32;
    localparam int COUNT_BITS  = 8;
    localparam int SLOT_BITS   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_PORT_W = 5;
    localparam int IDX_W       = (CNT_W > SLOT_PORT_W) ? CNT_W : SLOT_PORT_W;
    localparam int DEV_W       = 8;
    localparam int BLK_W       = 32;

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // Update applied by the addressed cell in the commit cycle.
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_FILL      = 3'd1,
        OP_VALID     = 3'd2,
        OP_VALID_INC = 3'd3,
        OP_INC       = 3'd4,
        OP_DEC       = 3'd5
    } t_op;

    // Running search result passed from cell to cell.
    typedef struct packed {
        logic                 found_hit;
        logic [SLOT_BITS-1:0] hit_slot;
        logic [SLOT_BITS-1:0] hit_rank;
        logic                 hit_valid;
        logic                 hit_max;
        logic                 found_free;
        logic [SLOT_BITS-1:0] free_slot;
        logic [SLOT_BITS-1:0] free_rank;
        logic                 addr_zero;
        logic                 addr_one;
        logic                 addr_max;
        logic [SLOT_BITS-1:0] addr_rank;
    } t_sweep;

    // Broadcast update from the controller to all cells.
    typedef struct packed {
        t_op                  op;
        logic [SLOT_BITS-1:0] slot;
        logic                 recent;
        logic [SLOT_BITS-1:0] rank;
    } t_commit;

endpackage

[hw/rtl/lru_block_buffer_cache_core.sv]
// A new command is accepted only while the core is idle, so not before the commit
// cycle of the previous command has ended: the request beat walks the chain of slot
// cells one cell per cycle, then one commit cycle updates the addressed cell and
// raises o_valid for exactly that cycle. busy is high from the cycle after acceptance
// through the commit cycle. The receiver cannot stall, so each result must be taken
// in its strobe cycle.
// Depends on lbc_pkg, lbc_cell and lru_block_buffer_cache_core_defines.svh.
`include "lru_block_buffer_cache_core_defines.svh"

module lru_block_buffer_cache_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_command,
    input  logic [lbc_pkg::DEV_W-1:0]        i_device_id,
    input  logic [lbc_pkg::BLK_W-1:0]        i_block_number,
    input  logic [lbc_pkg::SLOT_PORT_W-1:0]  i_slot_index,
    output logic                             o_valid,
    output logic [lbc_pkg::SLOT_PORT_W-1:0]  o_slot_out,
    output logic                             o_was_hit,
    output logic                             o_need_read,
    output logic [1:0]                       o_status
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [lbc_pkg::CNT_W-1:0]    r_cnt;
    logic [1:0]                   r_cmd;
    logic [lbc_pkg::DEV_W-1:0]    r_dev;
    logic [lbc_pkg::BLK_W-1:0]    r_blk;
    logic [lbc_pkg::IDX_W-1:0]    r_sidx;

    lbc_pkg::t_sweep              w_chain [lbc_pkg::NUM_SLOTS+1];
    lbc_pkg::t_sweep              w_res;
    lbc_pkg::t_commit             w_commit;
    logic [lbc_pkg::SLOT_BITS-1:0] w_slot;
    logic                         w_hit;
    logic                         w_read;
    lbc_pkg::t_status             w_status;
    logic                         w_in_range;

    assign w_chain[0] = '0;
    assign w_res      = w_chain[lbc_pkg::NUM_SLOTS];
    assign w_in_range = (r_sidx < lbc_pkg::IDX_W'(lbc_pkg::NUM_SLOTS));

    // Request registers, loaded when a command beat is accepted.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd  <= i_command;
            r_dev  <= i_device_id;
            r_blk  <= i_block_number;
            r_sidx <= lbc_pkg::IDX_W'(i_slot_index);
        end
    end

    // Sequencer: idle, walk the chain, commit.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_SWEEP;
            S_SWEEP:  if (r_cnt == lbc_pkg::CNT_W'(lbc_pkg::NUM_SLOTS - 1)) n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    assign busy = (r_state != S_IDLE);

    // Decide the answer and the update from the finished search result.
    always_comb begin
        w_slot          = r_sidx[lbc_pkg::SLOT_BITS-1:0];
        w_hit           = 1'b0;
        w_read          = 1'b0;
        w_status        = lbc_pkg::ST_OK;
        w_commit.op     = lbc_pkg::OP_NONE;
        w_commit.recent = 1'b0;
        w_commit.rank   = w_res.addr_rank;
        if (r_cmd == lbc_pkg::CMD_GET) begin
            if (w_res.found_hit) begin
                w_slot      = w_res.hit_slot;
                w_hit       = 1'b1;
                w_read      = !w_res.hit_valid;
                w_status    = w_res.hit_max ? lbc_pkg::ST_OVERFLOW : lbc_pkg::ST_OK;
                w_commit.op = w_res.hit_max ? lbc_pkg::OP_VALID : lbc_pkg::OP_VALID_INC;
            end else if (w_res.found_free) begin
                w_slot      = w_res.free_slot;
                w_read      = 1'b1;
                w_commit.op = lbc_pkg::OP_FILL;
            end else begin
                w_slot   = '0;
                w_status = lbc_pkg::ST_NO_FREE;
            end
        end else if (w_in_range) begin
            if (r_cmd == lbc_pkg::CMD_PIN) begin
                if (w_res.addr_max) begin
                    w_status = lbc_pkg::ST_OVERFLOW;
                end else begin
                    w_commit.op = lbc_pkg::OP_INC;
                end
            end else if (w_res.addr_zero) begin
                w_status = lbc_pkg::ST_UNDERFLOW;
            end else begin
                w_commit.op     = lbc_pkg::OP_DEC;
                w_commit.recent = (r_cmd == lbc_pkg::CMD_RELEASE) && w_res.addr_one;
            end
        end
        if (r_state != S_COMMIT) begin
            w_commit.op     = lbc_pkg::OP_NONE;
            w_commit.recent = 1'b0;
        end
        w_commit.slot = w_slot;
    end

    // Chain of slot cells; the search beat advances one cell per cycle.
    for (genvar g = 0; g < lbc_pkg::NUM_SLOTS; g++) begin : g_cell
        lbc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (lbc_pkg::SLOT_BITS'(g)),
            .i_dev    (r_dev),
            .i_blk    (r_blk),
            .i_sidx   (r_sidx),
            .i_sweep  (w_chain[g]),
            .i_commit (w_commit),
            .o_sweep  (w_chain[g+1])
        );
    end

    assign o_valid     = (r_state == S_COMMIT);
    assign o_slot_out  = lbc_pkg::SLOT_PORT_W'(lbc_pkg::IDX_W'(w_slot));
    assign o_was_hit   = w_hit;
    assign o_need_read = w_read;
    assign o_status    = w_status;

    // Checks on the sequencing and on the no-free-buffer answer.
    `LBC_ASSERT_NOW(a_valid_busy, o_valid, busy)
    `LBC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `LBC_ASSERT_NEXT(a_valid_single, o_valid, !o_valid && !busy)
    `LBC_ASSERT_NOW(a_nofree_fields, o_valid && o_status == lbc_pkg::ST_NO_FREE,
                    o_slot_out == '0 && !o_was_hit && !o_need_read)

endmodule

[hw/rtl/lbc_cell.sv]
// One buffer slot: tag, valid bit, reference count and recency rank.
// Depends on lbc_pkg; instantiated in a chain by lru_block_buffer_cache_core.
module lbc_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lbc_pkg::SLOT_BITS-1:0] i_idx,
    input  logic [lbc_pkg::DEV_W-1:0]    i_dev,
    input  logic [lbc_pkg::BLK_W-1:0]    i_blk,
    input  logic [lbc_pkg::IDX_W-1:0]    i_sidx,
    input  lbc_pkg::t_sweep              i_sweep,
    input  lbc_pkg::t_commit             i_commit,
    output lbc_pkg::t_sweep              o_sweep
);

    logic [lbc_pkg::DEV_W-1:0]      r_dev;
    logic [lbc_pkg::BLK_W-1:0]      r_blk;
    logic                           r_valid;
    logic [lbc_pkg::COUNT_BITS-1:0] r_count;
    logic [lbc_pkg::SLOT_BITS-1:0]  r_rank;
    lbc_pkg::t_sweep                r_sweep;
    lbc_pkg::t_sweep                n_sweep;

    logic w_match;
    logic w_zero;
    logic w_max;
    logic w_addr;
    logic w_sel;

    assign w_match = (r_dev == i_dev) && (r_blk == i_blk);
    assign w_zero  = (r_count == '0);
    assign w_max   = (r_count == {lbc_pkg::COUNT_BITS{1'b1}});
    assign w_addr  = (lbc_pkg::IDX_W'(i_idx) == i_sidx);
    assign w_sel   = (i_commit.slot == i_idx);

    // Fold this slot into the running search result.
    always_comb begin
        n_sweep = i_sweep;
        if (w_match && (!i_sweep.found_hit || r_rank > i_sweep.hit_rank)) begin
            n_sweep.found_hit = 1'b1;
            n_sweep.hit_slot  = i_idx;
            n_sweep.hit_rank  = r_rank;
            n_sweep.hit_valid = r_valid;
            n_sweep.hit_max   = w_max;
        end
        if (w_zero && (!i_sweep.found_free || r_rank < i_sweep.free_rank)) begin
            n_sweep.found_free = 1'b1;
            n_sweep.free_slot  = i_idx;
            n_sweep.free_rank  = r_rank;
        end
        if (w_addr) begin
            n_sweep.addr_zero = w_zero;
            n_sweep.addr_one  = (r_count == lbc_pkg::COUNT_BITS'(1));
            n_sweep.addr_max  = w_max;
            n_sweep.addr_rank = r_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep <= n_sweep;
    end

    assign o_sweep = r_sweep;

    // Slot state: cleared by reset (rank set to the slot index), updated only by the commit broadcast.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev   <= '0;
            r_blk   <= '0;
            r_valid <= 1'b0;
            r_count <= '0;
            r_rank  <= i_idx;
        end else begin
            if (w_sel) begin
                unique case (i_commit.op)
                    lbc_pkg::OP_FILL: begin
                        r_dev   <= i_dev;
                        r_blk   <= i_blk;
                        r_valid <= 1'b1;
                        r_count <= lbc_pkg::COUNT_BITS'(1);
                    end
                    lbc_pkg::OP_VALID: begin
                        r_valid <= 1'b1;
                    end
                    lbc_pkg::OP_VALID_INC: begin
                        r_valid <= 1'b1;
                        r_count <= r_count + 1'b1;
                    end
                    lbc_pkg::OP_INC: begin
                        r_count <= r_count + 1'b1;
                    end
                    lbc_pkg::OP_DEC: begin
                        r_count <= r_count - 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_commit.recent) begin
                if (w_sel) begin
                    r_rank <= lbc_pkg::SLOT_BITS'(lbc_pkg::NUM_SLOTS - 1);
                end else if (r_rank > i_commit.rank) begin
                    r_rank <= r_rank - 1'b1;
                end
            end
        end
    end

endmodule
